// ===== hdl/afc_pkg.sv =====
// Shared constants and types for the AABB frustum cull test block.
package afc_pkg;

    // Number of stored planes and fraction bits of the Q format
    localparam int PLANE_COUNT      = 6;
    localparam int FRAC_BITS        = 16;
    localparam int COEFFS_PER_PLANE = 4;
    localparam int STORE_DEPTH      = PLANE_COUNT * COEFFS_PER_PLANE;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int COORD_W          = 32;
    localparam int PROD_W           = 2 * COORD_W;
    // Three full products plus the scaled offset stay below 2^64 in magnitude
    localparam int ACC_W            = PROD_W + 2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // Coefficient codes within a plane
    localparam logic [1:0] COEFF_A = 2'd0;
    localparam logic [1:0] COEFF_B = 2'd1;
    localparam logic [1:0] COEFF_C = 2'd2;
    localparam logic [1:0] COEFF_D = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] corner_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic       load;       // latch box corners, clear accumulator and verdict
        logic       valid;      // one coefficient term issued this cycle
        logic [1:0] sel;        // which coefficient the term uses
        logic       plane_end;  // term closes the current plane
    } mac_ctrl_t;

endpackage

// ===== hdl/afc_plane_store.sv =====
// Register file holding the plane coefficients, cleared at reset.
module afc_plane_store
    import afc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [STORE_AW-1:0] wr_addr,
    input  coord_t              wr_data,
    input  logic [STORE_AW-1:0] rd_addr,
    output coord_t              rd_data
);

    coord_t store_reg [STORE_DEPTH];

    // Coefficient writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // Single read port for the sequencer
    assign rd_data = store_reg[rd_addr];

endmodule

// ===== hdl/afc_mac_unit.sv =====
// Shared multiplier and wide accumulator that evaluates one plane term per cycle.
module afc_mac_unit
    import afc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mac_ctrl_t ctrl,
    input  corner_t   box_min,
    input  corner_t   box_max,
    input  coord_t    coeff,
    output logic      culled
);

    corner_t                    min_reg;
    corner_t                    max_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       pvalid_reg;
    logic                       pend_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_sum;
    logic                       culled_reg;
    coord_t                     point;

    // Corner pick: max coordinate for a non-negative normal component
    always_comb
    begin
        case (ctrl.sel)
            COEFF_A: point = coeff[COORD_W-1] ? min_reg[0] : max_reg[0];
            COEFF_B: point = coeff[COORD_W-1] ? min_reg[1] : max_reg[1];
            COEFF_C: point = coeff[COORD_W-1] ? min_reg[2] : max_reg[2];
            default: point = '0;
        endcase
    end

    // Product or scaled offset term
    always_comb
    begin
        if (ctrl.sel == COEFF_D)
        begin
            prod_next = PROD_W'(coeff) <<< FRAC_BITS;
        end
        else
        begin
            prod_next = PROD_W'(coeff) * PROD_W'(point);
        end
    end

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    // Box corner latch and product register
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            min_reg <= box_min;
            max_reg <= box_max;
        end
        prod_reg <= prod_next;
    end

    // Term register control, accumulator and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            acc_reg    <= '0;
            culled_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            pvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            acc_reg    <= '0;
            culled_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctrl.valid;
            pend_reg   <= ctrl.plane_end;
            if (pvalid_reg)
            begin
                if (pend_reg)
                begin
                    // negative plane sum culls; zero counts as inside
                    culled_reg <= culled_reg | acc_sum[ACC_W-1];
                    acc_reg    <= '0;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    assign culled = culled_reg;

endmodule

// ===== hdl/aabb_frustum_cull_test.sv =====
// Top level of the AABB frustum cull test: command decode and plane sequencer.
//
// Input channel (in_valid/in_ready) carries one command per transfer. A write
// command (command = 0) stores coeff_value as coefficient coeff_index of plane
// plane_index; indexes at or above PLANE_COUNT are dropped. A write gives no
// result. A test command (command = 1) brings the box corners min_x..max_z
// and gives one result transfer on the output channel (out_valid/out_ready):
// visible = 1 unless some plane sum is negative.
// A test walks the four coefficients of every plane through one shared
// 32x32 multiplier, one term per cycle, then folds the last term into the
// verdict and moves it to the output register; in_ready is low meanwhile,
// so no new command is accepted before the test finishes.
// Writes are accepted back to back.
// The result sits in an output register, so the next command is accepted
// while it waits. If a second result is ready before the first is taken, the
// sequencer holds it and keeps in_ready low until the output register frees.
// Reset clears all planes to zero (an all-zero plane never culls) and empties
// the output register.
module aabb_frustum_cull_test
    import afc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [2:0]  plane_index,
    input  logic [1:0]  coeff_index,
    input  coord_t      coeff_value,
    input  coord_t      min_x,
    input  coord_t      min_y,
    input  coord_t      min_z,
    input  coord_t      max_x,
    input  coord_t      max_y,
    input  coord_t      max_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        visible
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STORE_AW-1:0] rd_addr_reg;
    logic [STORE_AW-1:0] rd_addr_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                visible_reg;
    logic                visible_next;
    logic                in_xfer;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [4:0]          wr_full_addr;
    coord_t              rd_data;
    mac_ctrl_t           ctrl;
    logic                culled;
    logic                last_term;
    corner_t             box_min;
    corner_t             box_max;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Write decode
    assign wr_full_addr = {plane_index, coeff_index};
    assign wr_addr      = wr_full_addr[STORE_AW-1:0];
    assign wr_en        = in_xfer && (command == CMD_WRITE)
                          && ({1'b0, plane_index} < 4'(PLANE_COUNT));

    assign box_min = {min_z, min_y, min_x};
    assign box_max = {max_z, max_y, max_x};

    afc_plane_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (coeff_value),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    afc_mac_unit u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .box_min (box_min),
        .box_max (box_max),
        .coeff   (rd_data),
        .culled  (culled)
    );

    assign last_term = (rd_addr_reg == STORE_AW'(STORE_DEPTH - 1));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg;
        visible_next   = visible_reg;
        ctrl           = '0;
        ctrl.sel       = rd_addr_reg[1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (command == CMD_TEST))
                begin
                    ctrl.load    = 1'b1;
                    rd_addr_next = '0;
                    state_next   = S_RUN;
                end
            end
            S_RUN:
            begin
                ctrl.valid     = 1'b1;
                ctrl.plane_end = (rd_addr_reg[1:0] == COEFF_D);
                // address wraps after the last coefficient
                rd_addr_next   = last_term ? '0 : rd_addr_reg + 1'b1;
                if (last_term)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last term is folded into the verdict this cycle
                state_next = S_POST;
            end
            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    visible_next   = !culled;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
            visible_reg   <= visible_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

// ===== sim/afc_visibility_check.sv =====
// Channel monitor for the AABB frustum cull test: plane store mirror, verdict prediction, compare.
module afc_visibility_check
    import afc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        command,
    input  logic [2:0]  plane_index,
    input  logic [1:0]  coeff_index,
    input  coord_t      coeff_value,
    input  coord_t      min_x,
    input  coord_t      min_y,
    input  coord_t      min_z,
    input  coord_t      max_x,
    input  coord_t      max_y,
    input  coord_t      max_z,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        visible,
    output int          fail_count,
    output int          pending_results
);

    // Mirror of the plane coefficients, entry plane*4 + coefficient
    coord_t planes [STORE_DEPTH];
    // Verdicts of accepted boxes, oldest first
    logic   visible_due [$];
    int     mismatches = 0;

    // Box survives unless some plane sum, taken at the corner farthest along
    // the normal, is negative. 96 bits hold every sum exactly.
    function automatic logic box_visible(input corner_t lo_c, input corner_t hi_c);
        logic signed [95:0] acc;
        logic signed [95:0] n_w;
        logic signed [95:0] q_w;
        logic               vis;
        vis = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                n_w = $signed(planes[p*COEFFS_PER_PLANE + j]);
                q_w = (n_w >= 0) ? $signed(hi_c[j]) : $signed(lo_c[j]);
                acc = acc + n_w * q_w;
            end
            n_w = $signed(planes[p*COEFFS_PER_PLANE + COEFF_D]);
            acc = acc + (n_w <<< FRAC_BITS);
            if (acc < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic exp_vis;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                planes[i] = '0;
            visible_due.delete();
            pending_results <= 0;
            fail_count      <= mismatches;
        end
        else
        begin
            // Result side first, so a box accepted on this edge is not taken
            if (out_valid && out_ready)
            begin
                if (visible_due.size() == 0)
                begin
                    $error("visible: no result expected, actual %0b", visible);
                    mismatches++;
                end
                else
                begin
                    exp_vis = visible_due.pop_front();
                    if (exp_vis !== visible)
                    begin
                        $error("visible: expected %0b, actual %0b", exp_vis, visible);
                        mismatches++;
                    end
                end
            end

            // Command side: writes update the mirror, tests queue a verdict
            if (in_valid && in_ready)
            begin
                if (command == CMD_WRITE)
                begin
                    if (plane_index < PLANE_COUNT)
                        planes[plane_index*COEFFS_PER_PLANE + coeff_index] = coeff_value;
                end
                else
                    visible_due.push_back(box_visible({min_z, min_y, min_x},
                                                      {max_z, max_y, max_x}));
            end

            pending_results <= visible_due.size();
            fail_count      <= mismatches;
        end
    end

endmodule

// ===== sim/aabb_frustum_cull_test_tb.sv =====
// Testbench top for the AABB frustum cull test: clock, reset, stimulus, back pressure, verdict.
module aabb_frustum_cull_test_tb
    import afc_pkg::*;
();

    localparam int     Q_ONE         = 1 << FRAC_BITS;
    localparam coord_t Q_MIN         = 32'sh8000_0000;
    localparam coord_t Q_MAX         = 32'sh7fff_ffff;
    localparam int     ITEMS_PHASE   = 160;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 400000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        command     = CMD_WRITE;
    logic [2:0]  plane_index = '0;
    logic [1:0]  coeff_index = COEFF_A;
    coord_t      coeff_value = '0;
    coord_t      min_x       = '0;
    coord_t      min_y       = '0;
    coord_t      min_z       = '0;
    coord_t      max_x       = '0;
    coord_t      max_y       = '0;
    coord_t      max_z       = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        visible;
    int          fail_count;
    int          pending_results;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        hold_done      = 1'b0;
    int          cycle_count    = 0;

    aabb_frustum_cull_test u_top (.*);

    afc_visibility_check u_check (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One command transfer; valid stays up across back-to-back items
    task automatic offer(input logic cmd, input logic [2:0] pi, input logic [1:0] ci,
                         input coord_t cv, input corner_t lo, input corner_t hi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        plane_index <= pi;
        coeff_index <= ci;
        coeff_value <= cv;
        min_x       <= lo[0];
        min_y       <= lo[1];
        min_z       <= lo[2];
        max_x       <= hi[0];
        max_y       <= hi[1];
        max_z       <= hi[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Unused fields carry noise
    task automatic write_coeff(input logic [2:0] pi, input logic [1:0] ci, input coord_t cv);
        offer(CMD_WRITE, pi, ci, cv, {$urandom, $urandom, $urandom},
              {$urandom, $urandom, $urandom});
    endtask

    task automatic test_box(input corner_t lo, input corner_t hi);
        offer(CMD_TEST, 3'($urandom), 2'($urandom), coord_t'($urandom), lo, hi);
    endtask

    task automatic write_plane(input logic [2:0] pi, input coord_t a, input coord_t b,
                               input coord_t c, input coord_t d);
        write_coeff(pi, COEFF_A, a);
        write_coeff(pi, COEFF_B, b);
        write_coeff(pi, COEFF_C, c);
        write_coeff(pi, COEFF_D, d);
    endtask

    // Uniform in [-span, span] whole units
    function automatic coord_t small_q(input int span);
        return coord_t'(int'($urandom_range(0, 2*span*Q_ONE)) - span*Q_ONE);
    endfunction

    function automatic coord_t rand_normal();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return coord_t'($urandom);
            3:
            begin
                case ($urandom_range(3))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
            default: return small_q(4);
        endcase
    endfunction

    // Offsets lean positive so a fair share of boxes survive all planes
    function automatic coord_t rand_offset();
        case ($urandom_range(9))
            0:       return '0;
            1:       return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 12*Q_ONE)) - 2*Q_ONE);
        endcase
    endfunction

    // Mostly ordered boxes of modest size; some full-range corners in any order
    task automatic random_test();
        corner_t lo;
        corner_t hi;
        for (int j = 0; j < 3; j++)
        begin
            if ($urandom_range(7) == 0)
            begin
                lo[j] = coord_t'($urandom);
                hi[j] = coord_t'($urandom);
            end
            else
            begin
                lo[j] = small_q(6);
                hi[j] = lo[j] + coord_t'($urandom_range(0, 4*Q_ONE));
            end
        end
        test_box(lo, hi);
    endtask

    task automatic random_item();
        int         pick;
        logic [1:0] ci;
        pick = $urandom_range(99);
        ci   = 2'($urandom_range(3));
        if (pick < 30)
            write_coeff(3'($urandom_range(PLANE_COUNT - 1)), ci,
                        (ci == COEFF_D) ? rand_offset() : rand_normal());
        else if (pick < 34)
            write_coeff(3'($urandom_range(7, PLANE_COUNT)), ci, coord_t'($urandom));
        else
            random_test();
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Untouched planes are all zero and never cull
        test_box('0, '0);
        // Writes beyond the last plane are dropped
        write_coeff(3'd6, COEFF_A, Q_MIN);
        write_coeff(3'd7, COEFF_D, coord_t'(-1));
        test_box({Q_MIN, Q_MIN, Q_MIN}, {Q_MIN, Q_MIN, Q_MIN});

        // x >= 0 half space: sum of zero is inside, just below is culled
        write_plane(3'd0, Q_ONE, '0, '0, '0);
        test_box('0, '0);
        test_box('0, {32'sd0, 32'sd0, -32'sd1});
        // Min above max: corners taken as given
        test_box({32'sd0, 32'sd0, coord_t'(5*Q_ONE)}, {32'sd0, 32'sd0, coord_t'(-5*Q_ONE)});

        // Extreme negative normals pick the minimum corner
        write_plane(3'd5, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        test_box({Q_MIN, Q_MIN, Q_MIN}, {Q_MAX, Q_MAX, Q_MAX});
        test_box({Q_MAX, Q_MAX, Q_MAX}, {Q_MAX, Q_MAX, Q_MAX});

        // Extreme positive normals pick the maximum corner
        write_plane(3'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        test_box({Q_MIN, Q_MIN, Q_MIN}, {Q_MIN, Q_MIN, Q_MIN});
        test_box({Q_MIN, Q_MIN, Q_MIN}, {Q_MAX, Q_MAX, Q_MAX});

        // Offset cancels one LSB of x exactly
        write_coeff(3'd0, COEFF_D, coord_t'(-1));
        test_box('0, {32'sd0, 32'sd0, 32'sd1});

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int k = 0; k < ITEMS_PHASE; k++)
            begin
                // Long hold-off while the sender keeps pushing
                if (ph == 0 && k == 40)
                    hold_request = 1'b1;
                random_item();
            end
        end
        in_valid <= 1'b0;

        // Let the count of the last transfer settle before waiting on it
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
